### rtl/core/kdlp_pkg.sv
// package for the key debounce and long-press unit
// holds sizes, per-key step and status codes, register indexes and the key command struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kdlp_pkg;

    // number of key machines and the width of each delay counter
    localparam int NUM_KEYS    = 4;
    localparam int DELAY_WIDTH = 16;

    // keys shown on the result ports
    localparam int OUT_KEYS    = 4;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int TICKS_W     = 16;

    localparam logic [TICKS_W-1:0]  DEBOUNCE_RESET   = TICKS_W'(20);
    localparam logic [TICKS_W-1:0]  LONG_PRESS_RESET = TICKS_W'(2000);
    localparam logic [OUT_KEYS-1:0] INVERT_RESET     = OUT_KEYS'(12);

    // input transaction kinds
    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_INVERT     = 2'd2
    } t_cfg_reg;

    // per-key machine steps
    typedef enum logic [2:0] {
        STEP_IDLE     = 3'd0,
        STEP_DEBOUNCE = 3'd1,
        STEP_CLICK    = 3'd2,
        STEP_HELD     = 3'd4,
        STEP_LONG1    = 3'd5,
        STEP_LONG2    = 3'd6
    } t_step;

    // reported status codes
    typedef enum logic [2:0] {
        STAT_NONE        = 3'd0,
        STAT_CLICK       = 3'd1,
        STAT_DOWN        = 3'd2,
        STAT_UP          = 3'd3,
        STAT_LONG_FIRST  = 3'd4,
        STAT_LONG_SECOND = 3'd5
    } t_status;

    // what one accepted transaction asks of a key machine
    typedef struct packed {
        logic scan;
        logic tick;
        logic pressed;
    } t_key_cmd;

endpackage

`default_nettype wire

### rtl/core/kdlp_key.sv
// one key machine: debounce, click, held down and two long-press stages
// depends on kdlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module kdlp_key
    import kdlp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_key_cmd               i_cmd,
    input  wire logic [DELAY_WIDTH-1:0] i_debounce_ticks,
    input  wire logic [DELAY_WIDTH-1:0] i_long_press_ticks,
    output t_status                     o_status,
    output logic                        o_enabled
);

    t_step                  r_step,      n_step;
    logic [DELAY_WIDTH-1:0] r_countdown, n_countdown;
    t_status                r_status,    n_status;
    logic                   r_enabled,   n_enabled;
    logic                   w_cd_zero;

    assign w_cd_zero = (r_countdown == '0);

    always_comb begin
        n_step      = r_step;
        n_countdown = r_countdown;
        n_status    = r_status;
        n_enabled   = r_enabled;
        if (i_cmd.tick) begin
            if (!w_cd_zero) begin
                n_countdown = r_countdown - DELAY_WIDTH'(1);
            end
        end else if (i_cmd.scan) begin
            unique case (r_step)
                STEP_IDLE: begin
                    if (i_cmd.pressed) begin
                        n_enabled   = 1'b1;
                        n_countdown = i_debounce_ticks;
                        n_step      = STEP_DEBOUNCE;
                    end else begin
                        n_status  = STAT_NONE;
                        n_enabled = 1'b0;
                    end
                end
                STEP_DEBOUNCE: begin
                    if (w_cd_zero) begin
                        if (i_cmd.pressed) begin
                            n_status = STAT_CLICK;
                            n_step   = STEP_CLICK;
                        end else begin
                            n_status  = STAT_NONE;
                            n_enabled = 1'b0;
                            n_step    = STEP_IDLE;
                        end
                    end
                end
                STEP_CLICK: begin
                    if (!i_cmd.pressed) begin
                        n_status  = STAT_UP;
                        n_enabled = 1'b0;
                        n_step    = STEP_IDLE;
                    end else begin
                        n_status    = STAT_DOWN;
                        n_countdown = i_long_press_ticks;
                        n_enabled   = 1'b1;
                        n_step      = STEP_HELD;
                    end
                end
                STEP_HELD: begin
                    if (i_cmd.pressed && w_cd_zero) begin
                        n_status    = STAT_LONG_FIRST;
                        n_countdown = i_long_press_ticks;
                        n_step      = STEP_LONG1;
                    end else if (!i_cmd.pressed) begin
                        n_status  = STAT_UP;
                        n_enabled = 1'b0;
                        n_step    = STEP_IDLE;
                    end
                end
                STEP_LONG1: begin
                    if (i_cmd.pressed && w_cd_zero) begin
                        n_status  = STAT_LONG_SECOND;
                        n_enabled = 1'b0;
                        n_step    = STEP_LONG2;
                    end else if (!i_cmd.pressed) begin
                        n_status  = STAT_NONE;
                        n_enabled = 1'b0;
                        n_step    = STEP_IDLE;
                    end
                end
                STEP_LONG2: begin
                    if (!i_cmd.pressed) begin
                        n_status  = STAT_NONE;
                        n_enabled = 1'b0;
                        n_step    = STEP_IDLE;
                    end
                end
                default: begin
                    // unreachable codes hold
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_countdown <= '0;
            r_status    <= STAT_NONE;
            r_enabled   <= 1'b1;
        end else begin
            r_step      <= n_step;
            r_countdown <= n_countdown;
            r_status    <= n_status;
            r_enabled   <= n_enabled;
        end
    end

    assign o_status  = r_status;
    assign o_enabled = r_enabled;

endmodule

`default_nettype wire

### rtl/core/key_debounce_long_press_unit.sv
// top level of the key debounce and long-press unit: handshakes, config registers, key machines
// depends on kdlp_pkg and kdlp_key
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input channel (i_in_valid / o_in_ready): each transaction is either a scan
//   (i_kind 0) carrying the raw pin levels of four keys, or a one-millisecond
//   tick (i_kind 1) that counts every key's delay counter down toward zero
// - result channel (o_out_valid / i_out_ready): one transaction per accepted
//   input, carrying each key's status code and the enable mask as they stand
//   after that input
// - config channel (i_cfg_valid / o_cfg_ready): index 0 debounce ticks,
//   1 long-press ticks, 2 invert mask; other indexes are dropped; always ready
// - result timing: the result is registered and shows in the cycle after the input is accepted
// - throughput: one transaction per cycle while results are taken, set by the single state
//   update of the per-key machines; the key state registers double as the result register
// - stall: while a result waits and the receiver holds i_out_ready low,
//   o_in_ready is low; input flows again in the cycle the result is taken
// - reset (i_rst_n low, synchronous): key machines idle, counters zero,
//   statuses none, enables set, config back to 20 / 2000 / 4'b1100, no result
//   pending
module key_debounce_long_press_unit
    import kdlp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input transactions
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_kind,
    input  wire logic [OUT_KEYS-1:0]   i_pin_levels,
    // result transactions
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [2:0]                 o_status_key0,
    output logic [2:0]                 o_status_key1,
    output logic [2:0]                 o_status_key2,
    output logic [2:0]                 o_status_key3,
    output logic [OUT_KEYS-1:0]        o_enable_mask,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ACTIVE_KEYS = (NUM_KEYS < OUT_KEYS) ? NUM_KEYS : OUT_KEYS;

    logic [TICKS_W-1:0]  r_debounce_ticks;
    logic [TICKS_W-1:0]  r_long_press_ticks;
    logic [OUT_KEYS-1:0] r_invert_mask;
    logic                r_out_valid;

    logic                   w_in_accept;
    logic                   w_cfg_accept;
    logic [OUT_KEYS-1:0]    w_pressed;
    logic [DELAY_WIDTH-1:0] w_debounce_load;
    logic [DELAY_WIDTH-1:0] w_long_load;
    t_status                w_status [OUT_KEYS];
    logic [OUT_KEYS-1:0]    w_enabled;

    // the key state only moves on an accepted transaction, and that only
    // happens while the result slot is empty or being drained
    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign w_in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready  = 1'b1;
    assign w_cfg_accept = i_cfg_valid;

    // level after polarity fix; low means pressed
    assign w_pressed = ~(i_pin_levels ^ r_invert_mask);

    // counters take the delay at their own width
    assign w_debounce_load = DELAY_WIDTH'(r_debounce_ticks);
    assign w_long_load     = DELAY_WIDTH'(r_long_press_ticks);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= DEBOUNCE_RESET;
            r_long_press_ticks <= LONG_PRESS_RESET;
            r_invert_mask      <= INVERT_RESET;
        end else if (w_cfg_accept) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_DEBOUNCE:   r_debounce_ticks   <= TICKS_W'(i_cfg_data);
                CFG_LONG_PRESS: r_long_press_ticks <= TICKS_W'(i_cfg_data);
                CFG_INVERT:     r_invert_mask      <= i_cfg_data[OUT_KEYS-1:0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // result pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // one machine per reported key; keys past the ports would never show,
    // and reported keys without a machine read as zero
    for (genvar k = 0; k < OUT_KEYS; k++) begin : g_key
        if (k < ACTIVE_KEYS) begin : g_on
            t_key_cmd w_cmd;

            assign w_cmd.scan    = w_in_accept && (i_kind == KIND_SCAN);
            assign w_cmd.tick    = w_in_accept && (i_kind == KIND_TICK);
            assign w_cmd.pressed = w_pressed[k];

            kdlp_key u_key (
                .i_clk              (i_clk),
                .i_rst_n            (i_rst_n),
                .i_cmd              (w_cmd),
                .i_debounce_ticks   (w_debounce_load),
                .i_long_press_ticks (w_long_load),
                .o_status           (w_status[k]),
                .o_enabled          (w_enabled[k])
            );
        end else begin : g_off
            assign w_status[k]  = STAT_NONE;
            assign w_enabled[k] = 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status_key0 = w_status[0];
    assign o_status_key1 = w_status[1];
    assign o_status_key2 = w_status[2];
    assign o_status_key3 = w_status[3];
    assign o_enable_mask = w_enabled;

endmodule

`default_nettype wire

### rtl/core/kdlp_checker.sv
// port-level checks for the key debounce and long-press unit, bound to the top level
// depends on kdlp_pkg and key_debounce_long_press_unit
`timescale 1ns / 1ps
`default_nettype none

module kdlp_checker
    import kdlp_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                i_kind,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic [2:0]          o_status_key0,
    input wire logic [2:0]          o_status_key1,
    input wire logic [2:0]          o_status_key2,
    input wire logic [2:0]          o_status_key3,
    input wire logic [OUT_KEYS-1:0] o_enable_mask
);

    // a pending result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_status_key0) && $stable(o_status_key1) &&
            $stable(o_status_key2) && $stable(o_status_key3) &&
            $stable(o_enable_mask))
        else $error("stalled result changed");

    // every accepted transaction yields a result in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted transaction gave no result");

    // a tick moves only the counters: statuses and enables hold
    a_tick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_kind == KIND_TICK) |=>
            $stable(o_status_key0) && $stable(o_status_key1) &&
            $stable(o_status_key2) && $stable(o_status_key3) &&
            $stable(o_enable_mask))
        else $error("tick changed a status or enable");

endmodule

bind key_debounce_long_press_unit kdlp_checker u_kdlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_kind        (i_kind),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status_key0 (o_status_key0),
    .o_status_key1 (o_status_key1),
    .o_status_key2 (o_status_key2),
    .o_status_key3 (o_status_key3),
    .o_enable_mask (o_enable_mask)
);

`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench for key_debounce_long_press_unit: directed table, then random phases
// predicts results from its own per-key model or the table's expectations, depends on kdlp_pkg and the rtl
`timescale 1ns / 1ps

module tb;
    import kdlp_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 8;
    localparam int TOTAL_ITEMS    = 1850;
    localparam int PHASES         = 8;
    localparam int HOLD_OFF_AT    = 500;      // results seen before the long receiver hold-off
    localparam int HOLD_OFF_LEN   = 120;
    localparam int DRAIN_CYCLES   = 8;
    localparam longint TIMEOUT_NS = 5_000_000;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // one result transaction as seen on the ports
    typedef struct packed {
        logic [OUT_KEYS-1:0][2:0] status;
        logic [OUT_KEYS-1:0]      enable;
    } t_key_report;

    localparam t_key_report NO_REPORT = '0;

    typedef enum logic [1:0] {
        PLAN_SCAN,
        PLAN_TICK,
        PLAN_CFG
    } t_plan_op;

    // value holds the pin levels for scans and ticks, the write data for config rows
    typedef struct packed {
        t_plan_op             op;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic                 has_exp;
        t_key_report          exp;
    } t_plan_row;

    localparam int PLAN_LEN = 30;

    // directed walk: reset behavior, then small delays so every step is reached in a few items
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        // tick right after reset: nothing moves, pins ignored, enables still set
        '{PLAN_TICK, '0, 16'h000F, 1'b1, '{{4{STAT_NONE}}, 4'hF}},
        // all pins high with reset mask 4'b1100: keys 2 and 3 pressed, 0 and 1 drop enable
        '{PLAN_SCAN, '0, 16'h000F, 1'b1, '{{4{STAT_NONE}}, 4'b1100}},
        '{PLAN_CFG, CFG_DEBOUNCE,   16'd1,    1'b0, NO_REPORT},
        '{PLAN_CFG, CFG_LONG_PRESS, 16'd2,    1'b0, NO_REPORT},
        '{PLAN_CFG, CFG_INVERT,     16'd0,    1'b0, NO_REPORT},
        // write to an index with no register must be dropped
        '{PLAN_CFG, CFG_UNUSED,     16'hFFFF, 1'b0, NO_REPORT},
        // key 0 alone through debounce, click, down, long first, long second
        '{PLAN_SCAN, '0, 16'h000E, 1'b0, NO_REPORT},
        '{PLAN_SCAN, '0, 16'h000E, 1'b0, NO_REPORT},
        '{PLAN_TICK, '0, 16'h0000, 1'b0, NO_REPORT},
        '{PLAN_SCAN, '0, 16'h000E, 1'b0, NO_REPORT},
        '{PLAN_SCAN, '0, 16'h000E, 1'b0, NO_REPORT},
        '{PLAN_SCAN, '0, 16'h000E, 1'b0, NO_REPORT},
        '{PLAN_TICK, '0, 16'h0005, 1'b0, NO_REPORT},
        '{PLAN_TICK, '0, 16'h000A, 1'b0, NO_REPORT},
        '{PLAN_SCAN, '0, 16'h000E, 1'b0, NO_REPORT},
        '{PLAN_TICK, '0, 16'h0000, 1'b0, NO_REPORT},
        '{PLAN_TICK, '0, 16'h000F, 1'b0, NO_REPORT},
        '{PLAN_SCAN, '0, 16'h000E, 1'b0, NO_REPORT},
        // release out of second long press
        '{PLAN_SCAN, '0, 16'h000F, 1'b0, NO_REPORT},
        // keys 0 and 1 pressed, then key 0 lets go in debounce while key 1 clicks
        '{PLAN_SCAN, '0, 16'h000C, 1'b0, NO_REPORT},
        '{PLAN_TICK, '0, 16'h0000, 1'b0, NO_REPORT},
        '{PLAN_SCAN, '0, 16'h000D, 1'b0, NO_REPORT},
        // key 1 released after click
        '{PLAN_SCAN, '0, 16'h000F, 1'b0, NO_REPORT},
        '{PLAN_CFG, CFG_DEBOUNCE, 16'd0,    1'b0, NO_REPORT},
        '{PLAN_CFG, CFG_INVERT,   16'hFFFF, 1'b0, NO_REPORT},
        // full inversion: pins high now mean pressed, then release from held
        '{PLAN_SCAN, '0, 16'h000F, 1'b0, NO_REPORT},
        '{PLAN_SCAN, '0, 16'h000F, 1'b0, NO_REPORT},
        '{PLAN_SCAN, '0, 16'h000F, 1'b0, NO_REPORT},
        '{PLAN_SCAN, '0, 16'h0000, 1'b0, NO_REPORT},
        '{PLAN_TICK, '0, 16'h0000, 1'b0, NO_REPORT}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_kind;
    logic [OUT_KEYS-1:0]   i_pin_levels;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [2:0]            o_status_key0;
    logic [2:0]            o_status_key1;
    logic [2:0]            o_status_key2;
    logic [2:0]            o_status_key3;
    logic [OUT_KEYS-1:0]   o_enable_mask;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    key_debounce_long_press_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_pin_levels  (i_pin_levels),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status_key0 (o_status_key0),
        .o_status_key1 (o_status_key1),
        .o_status_key2 (o_status_key2),
        .o_status_key3 (o_status_key3),
        .o_enable_mask (o_enable_mask),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predicted key state and register copies
    t_step                  pred_step      [NUM_KEYS];
    logic [DELAY_WIDTH-1:0] pred_countdown [NUM_KEYS];
    t_status                key_status     [NUM_KEYS];
    logic                   key_en         [NUM_KEYS];
    logic [TICKS_W-1:0]     debounce_cfg;
    logic [TICKS_W-1:0]     long_press_cfg;
    logic [OUT_KEYS-1:0]    invert_cfg;

    t_key_report pending_reports [$];   // expected results, oldest first
    int          reports_seen = 0;
    int          mismatches   = 0;
    int          items_sent   = 0;
    int          burst_left   = 0;

    function automatic void reset_keys();
        debounce_cfg   = DEBOUNCE_RESET;
        long_press_cfg = LONG_PRESS_RESET;
        invert_cfg     = INVERT_RESET;
        for (int k = 0; k < NUM_KEYS; k++) begin
            pred_step[k]      = STEP_IDLE;
            pred_countdown[k] = '0;
            key_status[k]     = STAT_NONE;
            key_en[k]         = 1'b1;
        end
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DEBOUNCE:   debounce_cfg   = TICKS_W'(data);
            CFG_LONG_PRESS: long_press_cfg = TICKS_W'(data);
            CFG_INVERT:     invert_cfg     = data[OUT_KEYS-1:0];
            default: ;      // no register, write dropped
        endcase
    endfunction

    // moves every key machine by one transaction and returns the result it should show
    function automatic t_key_report advance_keys(input logic kind,
                                                 input logic [OUT_KEYS-1:0] pins);
        t_key_report rep;
        logic        pressed;
        rep = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (kind == KIND_TICK) begin
                if (pred_countdown[k] != '0)
                    pred_countdown[k] = pred_countdown[k] - DELAY_WIDTH'(1);
            end else begin
                // level after inversion, low means pressed; keys past the ports read released
                pressed = (k < OUT_KEYS) ? !(pins[k] ^ invert_cfg[k]) : 1'b0;
                case (pred_step[k])
                    STEP_IDLE: begin
                        if (pressed) begin
                            key_en[k]         = 1'b1;
                            pred_countdown[k] = DELAY_WIDTH'(debounce_cfg);
                            pred_step[k]      = STEP_DEBOUNCE;
                        end else begin
                            key_status[k] = STAT_NONE;
                            key_en[k]     = 1'b0;
                        end
                    end
                    STEP_DEBOUNCE: begin
                        if (pred_countdown[k] == '0) begin
                            if (pressed) begin
                                key_status[k] = STAT_CLICK;
                                pred_step[k]  = STEP_CLICK;
                            end else begin
                                key_status[k] = STAT_NONE;
                                key_en[k]     = 1'b0;
                                pred_step[k]  = STEP_IDLE;
                            end
                        end
                    end
                    STEP_CLICK: begin
                        if (!pressed) begin
                            key_status[k] = STAT_UP;
                            key_en[k]     = 1'b0;
                            pred_step[k]  = STEP_IDLE;
                        end else begin
                            key_status[k]     = STAT_DOWN;
                            pred_countdown[k] = DELAY_WIDTH'(long_press_cfg);
                            key_en[k]         = 1'b1;
                            pred_step[k]      = STEP_HELD;
                        end
                    end
                    STEP_HELD: begin
                        if (pressed && pred_countdown[k] == '0) begin
                            key_status[k]     = STAT_LONG_FIRST;
                            pred_countdown[k] = DELAY_WIDTH'(long_press_cfg);
                            pred_step[k]      = STEP_LONG1;
                        end else if (!pressed) begin
                            key_status[k] = STAT_UP;
                            key_en[k]     = 1'b0;
                            pred_step[k]  = STEP_IDLE;
                        end
                    end
                    STEP_LONG1: begin
                        if (pressed && pred_countdown[k] == '0) begin
                            key_status[k] = STAT_LONG_SECOND;
                            key_en[k]     = 1'b0;
                            pred_step[k]  = STEP_LONG2;
                        end else if (!pressed) begin
                            key_status[k] = STAT_NONE;
                            key_en[k]     = 1'b0;
                            pred_step[k]  = STEP_IDLE;
                        end
                    end
                    STEP_LONG2: begin
                        if (!pressed) begin
                            key_status[k] = STAT_NONE;
                            key_en[k]     = 1'b0;
                            pred_step[k]  = STEP_IDLE;
                        end
                    end
                    default: ;  // unreachable codes hold
                endcase
            end
        end
        for (int k = 0; k < OUT_KEYS; k++) begin
            if (k < NUM_KEYS) begin
                rep.status[k] = key_status[k];
                rep.enable[k] = key_en[k];
            end
        end
        return rep;
    endfunction

    // offers one input transaction, with bursts and random gaps on the sender side
    task automatic offer_item(input logic kind, input logic [OUT_KEYS-1:0] pins,
                              input logic has_exp, input t_key_report typed);
        int          gap;
        t_key_report predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk) i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_pin_levels <= pins;
        do @(posedge i_clk); while (!o_in_ready);
        // transaction taken at this edge
        predicted = advance_keys(kind, pins);
        pending_reports.push_back(has_exp ? typed : predicted);
        items_sent++;
    endtask

    // stop offering and wait until every expected result has been taken
    task automatic drain_reports();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_reports();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, data);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // one well-formed hold of a pin pattern long enough to walk the machines, or a bit of noise
    task automatic run_episode(input int deb, input int lng);
        logic [OUT_KEYS-1:0] pattern;
        int                  reach;
        int                  len;
        if ($urandom_range(0, 9) < 7) begin
            pattern = OUT_KEYS'($urandom);
            reach   = 3 * (deb + 2 * lng) + 8;
            if (reach > 80) reach = 80;
            len = $urandom_range(2, reach);
            repeat (len) begin
                if ($urandom_range(0, 1) == 0)
                    offer_item(KIND_TICK, OUT_KEYS'($urandom), 1'b0, NO_REPORT);
                else if ($urandom_range(0, 19) == 0)
                    // single-sample glitch on one pin
                    offer_item(KIND_SCAN, pattern ^ (OUT_KEYS'(1) << $urandom_range(0, OUT_KEYS - 1)),
                               1'b0, NO_REPORT);
                else
                    offer_item(KIND_SCAN, pattern, 1'b0, NO_REPORT);
            end
        end else begin
            repeat ($urandom_range(1, 8))
                offer_item(1'($urandom), OUT_KEYS'($urandom), 1'b0, NO_REPORT);
        end
    endtask

    // main stimulus
    initial begin
        t_plan_row             row;
        int                    deb;
        int                    lng;
        logic [CFG_DATA_W-1:0] inv;
        int                    target;
        int                    per_phase;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = KIND_SCAN;
        i_pin_levels = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_DEBOUNCE;
        i_cfg_data   = '0;
        reset_keys();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < PLAN_LEN; i++) begin
            row = PLAN[i];
            if (row.op == PLAN_CFG)
                write_reg(row.cfg_idx, row.value);
            else
                offer_item((row.op == PLAN_TICK) ? KIND_TICK : KIND_SCAN,
                           row.value[OUT_KEYS-1:0], row.has_exp, row.exp);
        end

        // random phases, each under its own register setting
        per_phase = (TOTAL_ITEMS - items_sent) / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    deb = 0;
                    lng = 0;
                end
                1: begin
                    deb = 65535;
                    lng = 65535;
                end
                default: begin
                    deb = $urandom_range(0, 3);
                    lng = $urandom_range(0, 6);
                end
            endcase
            // upper data bits of the mask write are random and must be dropped
            inv = CFG_DATA_W'($urandom);
            if (ph == 1) inv[OUT_KEYS-1:0] = '1;
            if (ph == 2) inv[OUT_KEYS-1:0] = '0;
            write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
            write_reg(CFG_LONG_PRESS, CFG_DATA_W'(lng));
            write_reg(CFG_INVERT, inv);
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            target = items_sent + per_phase;
            while (items_sent < target) run_episode(deb, lng);
        end

        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // receiver: stall pattern changes after each random span, plus one long hold-off
    initial begin
        int  mode;
        int  span;
        bit  held_off;
        held_off    = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 80);
            repeat (span) begin
                @(negedge i_clk);
                if (!held_off && reports_seen >= HOLD_OFF_AT) begin
                    // long hold-off so the result register fills and the input stalls
                    held_off = 1'b1;
                    i_out_ready <= 1'b0;
                    repeat (HOLD_OFF_LEN) @(negedge i_clk);
                end
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result checker, compares each taken transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_key_report got;
        t_key_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status[0] = o_status_key0;
            got.status[1] = o_status_key1;
            got.status[2] = o_status_key2;
            got.status[3] = o_status_key3;
            got.enable    = o_enable_mask;
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                $display("%0t: expected no result, got status %h enable %b",
                         $time, got.status, got.enable);
            end else begin
                want = pending_reports.pop_front();
                for (int k = 0; k < OUT_KEYS; k++) begin
                    if (got.status[k] !== want.status[k]) begin
                        mismatches++;
                        $display("%0t: key%0d status expected %0d got %0d",
                                 $time, k, want.status[k], got.status[k]);
                    end
                end
                if (got.enable !== want.enable) begin
                    mismatches++;
                    $display("%0t: enable mask expected %b got %b",
                             $time, want.enable, got.enable);
                end
            end
        end
    end

    // hard stop
    initial begin
        #(TIMEOUT_NS);
        $display("tb: errors");
        $finish;
    end

endmodule
